[src/xokvs_pkg.sv]
// Package for the three-hash XOR key-value table decoder.
// Holds request/result types, table sizes and hash constants.
// No dependencies.
package xokvs_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = ADDR_W + 1;

    localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(17);
    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(TABLE_DEPTH);

    localparam logic [63:0] SEED_MIX = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MUL_C1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MUL_C2   = 64'h94d049bb133111eb;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    localparam logic [2:0] ADDR_ACTIVE_SIZE = 3'd0;

    typedef struct packed {
        logic        req_type;
        logic [11:0] entry_index;
        logic [63:0] entry_lo;
        logic [63:0] entry_hi;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
    } req_t;

    typedef struct packed {
        logic [63:0] value_lo;
        logic [63:0] value_hi;
        logic        write_ignored;
    } rsp_t;

endpackage

[src/xor_okvs_three_hash_decode_top.sv]
// Three-hash XOR key-value table decoder: top level, uses xokvs_pkg and xokvs_ram.
// Holds the APB register, the hash/remainder sequencer and the two table halves.
//
// The block stores 128-bit entries in two 64-bit by 4096 RAMs and answers one
// request at a time. A write request goes from acceptance straight to the result
// (it is dropped and flagged when the index is at or past the active size). A decode
// request computes three table positions in turn: each is drawn with the shared
// 32x32 multiplier (three partial products per 64-bit multiply, two multiplies per
// draw) and reduced by the bit-serial remainder unit; collision fixing and the three
// table reads follow. A decode with an active size below 17 returns zero without
// any hashing. The next request is taken as soon as the sequencer is idle, even while
// a result waits.
module xor_okvs_three_hash_decode_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  xokvs_pkg::req_t      in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output xokvs_pkg::rsp_t      out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    import xokvs_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADD  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_X27  = 4'd3;
    localparam logic [3:0] S_X31  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_FIX1 = 4'd6;
    localparam logic [3:0] S_FIX2 = 4'd7;
    localparam logic [3:0] S_READ = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [SIZE_W-1:0] active_size_reg;
    logic [SIZE_W-1:0] eff_size;
    logic [63:0]       s_reg, s_next;
    logic [63:0]       z_reg, z_next;
    logic [63:0]       acc_reg, acc_next;
    logic [1:0]        ph_reg, ph_next;
    logic              sel_reg, sel_next;
    logic [1:0]        k_reg, k_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [ADDR_W-1:0] p0_reg, p0_next;
    logic [ADDR_W-1:0] p1_reg, p1_next;
    logic [ADDR_W-1:0] p2_reg, p2_next;
    logic [63:0]       vlo_reg, vlo_next;
    logic [63:0]       vhi_reg, vhi_next;
    rsp_t              res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_data_reg, out_data_next;

    logic              accept;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [63:0]       rd_lo, rd_hi;
    logic [63:0]       sn;
    logic [63:0]       mul_c;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod;
    logic [SIZE_W:0]   div_try;
    logic [SIZE_W-1:0] div_r;
    logic              idx_out;

    function automatic logic [ADDR_W-1:0] add_wrap(input logic [ADDR_W-1:0] p,
                                                   input logic [1:0] inc,
                                                   input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] sum;
        sum = {1'b0, p} + SIZE_W'(inc);
        if (sum >= size)
        begin
            sum = sum - size;
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign eff_size = (active_size_reg > MAX_SIZE) ? MAX_SIZE : active_size_reg;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign idx_out  = ({1'b0, in_data.entry_index} >= eff_size);
    assign ram_we   = accept && (in_data.req_type == REQ_WRITE) && !idx_out;

    assign pready = 1'b1;
    assign prdata = {{(32-SIZE_W){1'b0}}, active_size_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_ACTIVE_SIZE)
        begin
            active_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // shared multiplier: three low-half partial products per 64-bit multiply
    assign mul_c = sel_reg ? MUL_C2 : MUL_C1;
    assign mul_a = (ph_reg == 2'd2) ? z_reg[63:32] : z_reg[31:0];
    assign mul_b = (ph_reg == 2'd1) ? mul_c[63:32] : mul_c[31:0];
    assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

    assign sn = s_reg + SEED_MIX;

    // one remainder bit a cycle
    assign div_try = {rem_reg, z_reg[63]};
    assign div_r = (div_try >= {1'b0, eff_size}) ? SIZE_W'(div_try - {1'b0, eff_size})
                                                : div_try[SIZE_W-1:0];

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    ram_raddr = p0_reg;
            2'd1:    ram_raddr = p1_reg;
            default: ram_raddr = p2_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        ph_next        = ph_reg;
        sel_next       = sel_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        vlo_next       = vlo_reg;
        vhi_next       = vhi_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    if (in_data.req_type == REQ_WRITE)
                    begin
                        res_next.write_ignored = idx_out;
                        state_next = S_DONE;
                    end
                    else if (eff_size < MIN_SIZE)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        s_next     = in_data.key_lo ^ (in_data.key_hi << 1) ^ SEED_MIX;
                        k_next     = 2'd0;
                        state_next = S_ADD;
                    end
                end
            end
            S_ADD:
            begin
                s_next     = sn;
                z_next     = sn ^ (sn >> 30);
                sel_next   = 1'b0;
                ph_next    = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        acc_next = prod;
                        ph_next  = 2'd1;
                    end
                    2'd1:
                    begin
                        acc_next = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                        ph_next  = 2'd2;
                    end
                    default:
                    begin
                        z_next     = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                        ph_next    = 2'd0;
                        state_next = sel_reg ? S_X31 : S_X27;
                    end
                endcase
            end
            S_X27:
            begin
                z_next     = z_reg ^ (z_reg >> 27);
                sel_next   = 1'b1;
                state_next = S_MUL;
            end
            S_X31:
            begin
                z_next     = z_reg ^ (z_reg >> 31);
                cnt_next   = '0;
                rem_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = div_r;
                z_next   = {z_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    case (k_reg)
                        2'd0:    p0_next = div_r[ADDR_W-1:0];
                        2'd1:    p1_next = div_r[ADDR_W-1:0];
                        default: p2_next = div_r[ADDR_W-1:0];
                    endcase
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd2) ? S_FIX1 : S_ADD;
                end
            end
            S_FIX1:
            begin
                if (p1_reg == p0_reg)
                begin
                    p1_next = add_wrap(p1_reg, 2'd2, eff_size);
                end
                cnt_next   = '0;
                state_next = S_FIX2;
            end
            S_FIX2:
            begin
                if (p2_reg == p0_reg || p2_reg == p1_reg)
                begin
                    p2_next = add_wrap(p2_reg, 2'd3, eff_size);
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd2)
                begin
                    cnt_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // read data arrives in the cycle after its address
                cnt_next = cnt_reg + 6'd1;
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                    end
                    2'd1:
                    begin
                        vlo_next = rd_lo;
                        vhi_next = rd_hi;
                    end
                    2'd2:
                    begin
                        vlo_next = vlo_reg ^ rd_lo;
                        vhi_next = vhi_reg ^ rd_hi;
                    end
                    default:
                    begin
                        res_next.value_lo      = vlo_reg ^ rd_lo;
                        res_next.value_hi      = vhi_reg ^ rd_hi;
                        res_next.write_ignored = 1'b0;
                        state_next             = S_DONE;
                    end
                endcase
            end
            S_DONE:
            begin
                // hold until the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ph_reg        <= '0;
            sel_reg       <= 1'b0;
            k_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ph_reg        <= ph_next;
            sel_reg       <= sel_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        z_reg        <= z_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        vlo_reg      <= vlo_next;
        vhi_reg      <= vhi_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    xokvs_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_store_lo (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_data.entry_index),
        .wdata (in_data.entry_lo),
        .raddr (ram_raddr),
        .rdata (rd_lo)
    );

    xokvs_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_store_hi (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_data.entry_index),
        .wdata (in_data.entry_hi),
        .raddr (ram_raddr),
        .rdata (rd_hi)
    );

    a_div_size: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (eff_size >= MIN_SIZE))
        else $error("remainder unit running with an empty table");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |->
        ({1'b0, p0_reg} < eff_size && {1'b0, p1_reg} < eff_size
         && {1'b0, p2_reg} < eff_size))
        else $error("table position outside table size");

    a_fix1: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIX2) |-> (p1_reg != p0_reg))
        else $error("second position still collides with first");

    a_done_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || !out_stall)) |=> out_valid_reg)
        else $error("finished result not moved to output register");

endmodule

[src/xokvs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// Width and depth are parameters; no package dependency.
module xokvs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
